### design/ttrf_pkg.sv
// Shared types, constants and helper functions for the touch tap-repeat filter.
// Used by every module of the block; depends on nothing.
package ttrf_pkg;

  localparam int CoordBits = 16;
  localparam int CfgW      = 16;
  localparam int OtherW    = 8;
  localparam int ClockW    = 32;
  localparam int FlagW     = 4;

  // tdata holds the four flags, the other bits, x and y, padded to bytes
  localparam int PayW      = FlagW + OtherW + 2 * CoordBits;
  localparam int DataW     = ((PayW + 7) / 8) * 8;

  // distance compare width: one bit over the coordinate, at least the register
  localparam int DistW     = (CoordBits + 1 > CfgW) ? CoordBits + 1 : CfgW;

  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam int CfgAddrW  = 3;

  typedef enum logic [CfgAddrW-1:0] {
    CfgAreaX      = 3'd0,
    CfgAreaY      = 3'd1,
    CfgRepeat     = 3'd2,
    CfgHoldDelay  = 3'd3,
    CfgMoveStep   = 3'd4
  } cfg_idx_e;

  // sample class codes, {valid, down, prev_down, ignore}
  localparam logic [FlagW-1:0] ClsDown  = 4'b1100;
  localparam logic [FlagW-1:0] ClsUp    = 4'b1010;
  localparam logic [FlagW-1:0] ClsMove  = 4'b1110;
  localparam logic [FlagW-1:0] ClsHover = 4'b1000;

  typedef struct packed {
    logic [CfgW-1:0] area_x;
    logic [CfgW-1:0] area_y;
    logic [CfgW-1:0] repeat_interval;
    logic [CfgW-1:0] hold_delay;
    logic [CfgW-1:0] move_step;
  } cfg_t;

  typedef struct packed {
    logic                        valid_bit;
    logic                        down_bit;
    logic                        prev_down_bit;
    logic                        ignore_bit;
    logic [OtherW-1:0]           other_bits;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic                        from_hold;
    logic                        last_of_run;
  } res_t;

  // |a - b| <= lim, computed exactly without wrap
  function automatic logic near(input logic signed [CoordBits-1:0] a,
                                input logic signed [CoordBits-1:0] b,
                                input logic [CfgW-1:0] lim);
    logic signed [CoordBits:0] diff;
    logic [CoordBits:0]        mag;
    diff = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    mag  = diff[CoordBits] ? (~diff + 1'b1) : diff;
    return DistW'(mag) <= DistW'(lim);
  endfunction

endpackage

### design/ttrf_cfg.sv
// Configuration register file of the touch tap-repeat filter.
// Depends on ttrf_pkg for the register index codes and the cfg_t struct.
module ttrf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [ttrf_pkg::CfgAddrW-1:0]   addr_i,
  input  logic [ttrf_pkg::CfgW-1:0]       data_i,
  output ttrf_pkg::cfg_t                  cfg_o
);
  import ttrf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (addr_i)
        CfgAreaX:     cfg_d.area_x          = data_i;
        CfgAreaY:     cfg_d.area_y          = data_i;
        CfgRepeat:    cfg_d.repeat_interval = data_i;
        CfgHoldDelay: cfg_d.hold_delay      = data_i;
        CfgMoveStep:  cfg_d.move_step       = data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_x          <= CfgW'(16);
      cfg_q.area_y          <= CfgW'(16);
      cfg_q.repeat_interval <= CfgW'(300);
      cfg_q.hold_delay      <= CfgW'(100);
      cfg_q.move_step       <= CfgW'(5);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/ttrf_core.sv
// Filter state and per-item decision logic: classifies an item, updates the
// hold, up and move records and produces zero, one or two results.
// Depends on ttrf_pkg.
module ttrf_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ttrf_pkg::cfg_t                     cfg_i,
  input  logic                               accept_i,
  input  logic                               cmd_i,
  input  logic [ttrf_pkg::FlagW-1:0]         flags_i,
  input  logic [ttrf_pkg::OtherW-1:0]        other_i,
  input  logic signed [ttrf_pkg::CoordBits-1:0] x_i,
  input  logic signed [ttrf_pkg::CoordBits-1:0] y_i,
  output logic [1:0]                         push_n_o,
  output ttrf_pkg::res_t                     res0_o,
  output ttrf_pkg::res_t                     res1_o
);
  import ttrf_pkg::*;

  logic                        pending_q, pending_d;
  logic [CfgW-1:0]             left_q, left_d;
  logic [ClockW-1:0]           clock_q, clock_d;
  logic [ClockW-1:0]           up_time_q, up_time_d;
  logic signed [CoordBits-1:0] up_x_q, up_x_d, up_y_q, up_y_d;
  logic signed [CoordBits-1:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic [OtherW-1:0]           held_oth_q, held_oth_d;
  logic signed [CoordBits-1:0] mv_x_q, mv_x_d, mv_y_q, mv_y_d;

  logic       near_up, near_mv_area, near_mv_step, recent;
  logic [ClockW-1:0] since_up;
  res_t       samp, held;
  logic [1:0] n;
  res_t       r0, r1;

  assign since_up     = clock_q - up_time_q;
  assign recent       = since_up <= ClockW'(cfg_i.repeat_interval);
  assign near_up      = near(x_i, up_x_q, cfg_i.area_x) && near(y_i, up_y_q, cfg_i.area_y);
  assign near_mv_area = near(x_i, mv_x_q, cfg_i.area_x) && near(y_i, mv_y_q, cfg_i.area_y);
  assign near_mv_step = near(x_i, mv_x_q, cfg_i.move_step) &&
                        near(y_i, mv_y_q, cfg_i.move_step);

  always_comb begin
    samp = '{valid_bit: flags_i[3], down_bit: flags_i[2], prev_down_bit: flags_i[1],
             ignore_bit: flags_i[0], other_bits: other_i, x: x_i, y: y_i,
             from_hold: 1'b0, last_of_run: 1'b0};
    held = '{valid_bit: 1'b1, down_bit: 1'b1, prev_down_bit: 1'b0, ignore_bit: 1'b0,
             other_bits: held_oth_q, x: held_x_q, y: held_y_q,
             from_hold: 1'b1, last_of_run: 1'b0};
  end

  always_comb begin
    pending_d  = pending_q;
    left_d     = left_q;
    clock_d    = clock_q;
    up_time_d  = up_time_q;
    up_x_d     = up_x_q;
    up_y_d     = up_y_q;
    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    held_oth_d = held_oth_q;
    mv_x_d     = mv_x_q;
    mv_y_d     = mv_y_q;
    n          = 2'd0;
    r0         = samp;
    r1         = samp;

    if (cmd_i) begin
      clock_d = clock_q + 1'b1;
      if (pending_q) begin
        if (left_q <= CfgW'(1)) begin
          pending_d = 1'b0;
          left_d    = '0;
          r0        = held;
          n         = 2'd1;
        end else begin
          left_d = left_q - 1'b1;
        end
      end
    end else begin
      case (flags_i)
        ClsDown: begin
          if (near_up && recent) begin
            // suspect repeat tap: hold it back, restart the count
            held_x_d   = x_i;
            held_y_d   = y_i;
            held_oth_d = other_i;
            pending_d  = 1'b1;
            left_d     = cfg_i.hold_delay;
          end else begin
            mv_x_d    = x_i;
            mv_y_d    = y_i;
            pending_d = 1'b0;
            n         = 2'd1;
          end
        end
        ClsUp: begin
          up_x_d    = x_i;
          up_y_d    = y_i;
          up_time_d = clock_q;
          pending_d = 1'b0;
          // a pending hold is cancelled and swallows the up
          if (!pending_q) n = 2'd1;
        end
        ClsMove: begin
          if (!(pending_q && near_mv_area)) begin
            if (pending_q) begin
              pending_d = 1'b0;
              r0        = held;
            end
            if (!near_mv_step) begin
              mv_x_d = x_i;
              mv_y_d = y_i;
              if (pending_q) r1 = samp;
              else           r0 = samp;
            end
            n = 2'({1'b0, pending_q} + {1'b0, !near_mv_step});
          end
        end
        ClsHover: n = 2'd0;
        default:  n = 2'd1;
      endcase
    end

    // mark the final result of this item
    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 1'b0;
      left_q     <= '0;
      clock_q    <= '0;
      up_time_q  <= '0;
      up_x_q     <= '0;
      up_y_q     <= '0;
      held_x_q   <= '0;
      held_y_q   <= '0;
      held_oth_q <= '0;
      mv_x_q     <= '0;
      mv_y_q     <= '0;
    end else if (accept_i) begin
      pending_q  <= pending_d;
      left_q     <= left_d;
      clock_q    <= clock_d;
      up_time_q  <= up_time_d;
      up_x_q     <= up_x_d;
      up_y_q     <= up_y_d;
      held_x_q   <= held_x_d;
      held_y_q   <= held_y_d;
      held_oth_q <= held_oth_d;
      mv_x_q     <= mv_x_d;
      mv_y_q     <= mv_y_d;
    end
  end

  assign push_n_o = accept_i ? n : 2'd0;
  assign res0_o   = r0;
  assign res1_o   = r1;

endmodule

### design/ttrf_outq.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while ready_i is high.
// Depends on ttrf_pkg for res_t and the queue sizing.
module ttrf_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  ttrf_pkg::res_t   push0_i,
  input  ttrf_pkg::res_t   push1_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output ttrf_pkg::res_t   head_o
);
  import ttrf_pkg::*;

  res_t             ent_q [QDepth];
  logic [QPtrW-1:0] head_q, head_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QPtrW-1:0] tail0, tail1;
  logic             pop;

  assign pop    = valid_o && ready_i;
  assign tail0  = head_q + cnt_q[QPtrW-1:0];
  assign tail1  = tail0 + 1'b1;
  assign head_d = pop ? head_q + 1'b1 : head_q;
  assign cnt_d  = cnt_q + QCntW'(push_n_i) - QCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) ent_q[tail0] <= push0_i;
    if (push_n_i == 2'd2) ent_q[tail1] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  // keep room for the two results one item may cause
  assign room_o  = cnt_q <= QCntW'(QDepth - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = ent_q[head_q];

endmodule

### design/touch_tap_repeat_filter.sv
// Touch tap-repeat filter, top level: config registers, filter core, result queue.
// Results are registered in the result queue before they reach the master side.
// Throughput: one item per cycle while the queue has room; results leave singly
// from the four-entry result queue, which accepts with at least two free slots.
// Reset (rst_ni low, asynchronous) clears the filter state, empties the queue and
// loads the register defaults.
module touch_tap_repeat_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ttrf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ttrf_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // valid_bit, down_bit, prev_down_bit, ignore_bit, other_bits, pos_x, pos_y, zero pad
  input  logic [ttrf_pkg::DataW-1:0]   s_axis_tdata_i,
  // cmd
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // out_valid_bit, out_down_bit, out_prev_down_bit, out_ignore_bit, out_other_bits,
  // out_x, out_y, zero pad
  output logic [ttrf_pkg::DataW-1:0]   m_axis_tdata_o,
  // from_hold
  output logic                         m_axis_tuser_o,
  // last_of_run
  output logic                         m_axis_tlast_o
);
  import ttrf_pkg::*;

  cfg_t       cfg;
  logic       accept;
  logic [1:0] push_n;
  res_t       res0, res1, head;
  logic       room;

  localparam int XLo = FlagW + OtherW;
  localparam int YLo = XLo + CoordBits;

  ttrf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .addr_i (cfg_addr_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  ttrf_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .cmd_i    (s_axis_tuser_i),
    .flags_i  ({s_axis_tdata_i[0], s_axis_tdata_i[1], s_axis_tdata_i[2], s_axis_tdata_i[3]}),
    .other_i  (s_axis_tdata_i[FlagW +: OtherW]),
    .x_i      (s_axis_tdata_i[XLo +: CoordBits]),
    .y_i      (s_axis_tdata_i[YLo +: CoordBits]),
    .push_n_o (push_n),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  ttrf_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res0),
    .push1_i  (res1),
    .room_o   (room),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .head_o   (head)
  );

  assign m_axis_tdata_o = DataW'({head.y, head.x, head.other_bits, head.ignore_bit,
                                  head.prev_down_bit, head.down_bit, head.valid_bit});
  assign m_axis_tuser_o = head.from_hold;
  assign m_axis_tlast_o = head.last_of_run;

endmodule

### design/ttrf_checker.sv
// Port-level checks for the touch tap-repeat filter, bound to the top level.
// Depends on ttrf_pkg for the data width.
module ttrf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [ttrf_pkg::DataW-1:0] m_axis_tdata_o,
  input logic                       m_axis_tuser_o,
  input logic                       m_axis_tlast_o
);
  import ttrf_pkg::*;

  // nothing leaves once reset has been seen at an edge and until it is released
  a_quiet_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result offered during reset");

  // a released held pen-down always carries the down flags
  a_held_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[FlagW-1:0] == 4'b0011))
    else $error("held pen-down released with wrong flags");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind touch_tap_repeat_filter ttrf_checker u_ttrf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### tb/sv/tb.sv
// Self-checking bench for touch_tap_repeat_filter: drives touch strokes, ms ticks and noise
// into the input stream and checks every output item against a behavioral predictor.
// Depends on ttrf_pkg and the touch_tap_repeat_filter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttrf_pkg::*;

  localparam int StallLimit    = 5000;
  localparam int SettleCycles  = 4;
  localparam int HoldoffCycles = 250;
  localparam int NumRegs       = 5;

  // flag patterns that fall outside the four filtered classes
  localparam logic [FlagW-1:0] OddFlags    = 4'b0111;
  localparam logic [FlagW-1:0] DownIgnored = 4'b1101;

  localparam logic signed [CoordBits-1:0] MaxCoord = {1'b0, {(CoordBits - 1){1'b1}}};
  localparam logic signed [CoordBits-1:0] MinCoord = {1'b1, {(CoordBits - 1){1'b0}}};

  // tdata layout, lowest field last
  typedef struct packed {
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
    logic [OtherW-1:0]           other_bits;
    logic                        ignore_bit;
    logic                        prev_down_bit;
    logic                        down_bit;
    logic                        valid_bit;
  } touch_t;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgW-1:0]     cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DataW-1:0]    in_data  = '0;
  logic                in_cmd   = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DataW-1:0]    out_data;
  logic                out_hold;
  logic                out_last;

  // predictor copy of the filter registers and state
  logic [CfgW-1:0]             spot_dx      = 16;
  logic [CfgW-1:0]             spot_dy      = 16;
  logic [CfgW-1:0]             retap_window = 300;
  logic [CfgW-1:0]             park_ticks   = 100;
  logic [CfgW-1:0]             jog_min      = 5;
  logic                        holding      = 1'b0;
  logic [CfgW-1:0]             hold_count   = '0;
  logic [ClockW-1:0]           now_ms       = '0;
  logic [ClockW-1:0]           lift_ms      = '0;
  logic signed [CoordBits-1:0] lift_x       = '0;
  logic signed [CoordBits-1:0] lift_y       = '0;
  logic signed [CoordBits-1:0] parked_x     = '0;
  logic signed [CoordBits-1:0] parked_y     = '0;
  logic [OtherW-1:0]           parked_other = '0;
  logic signed [CoordBits-1:0] anchor_x     = '0;
  logic signed [CoordBits-1:0] anchor_y     = '0;

  res_t reports_due[$];
  int   mismatch_count = 0;
  int   items_sent     = 0;
  bit   tx_idle_en     = 1'b1;
  bit   rx_idle_en     = 1'b1;
  int   rx_holdoff     = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  touch_tap_repeat_filter u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_cmd),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_hold),
    .m_axis_tlast_o  (out_last)
  );

  function automatic bit within_dist(input logic signed [CoordBits-1:0] a,
                                     input logic signed [CoordBits-1:0] b,
                                     input logic [CfgW-1:0] lim);
    int gap;
    gap = int'(a) - int'(b);
    if (gap < 0) gap = -gap;
    return gap <= int'(lim);
  endfunction

  function automatic res_t echo_report(input touch_t t);
    res_t r;
    r.valid_bit     = t.valid_bit;
    r.down_bit      = t.down_bit;
    r.prev_down_bit = t.prev_down_bit;
    r.ignore_bit    = t.ignore_bit;
    r.other_bits    = t.other_bits;
    r.x             = t.x;
    r.y             = t.y;
    r.from_hold     = 1'b0;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic res_t parked_report();
    res_t r;
    r.valid_bit     = 1'b1;
    r.down_bit      = 1'b1;
    r.prev_down_bit = 1'b0;
    r.ignore_bit    = 1'b0;
    r.other_bits    = parked_other;
    r.x             = parked_x;
    r.y             = parked_y;
    r.from_hold     = 1'b1;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // work out the output items one accepted input item causes and queue them
  function automatic void predict_reports(input logic is_tick, input touch_t t);
    res_t             outs[$];
    logic [FlagW-1:0] kind;
    kind = {t.valid_bit, t.down_bit, t.prev_down_bit, t.ignore_bit};
    if (is_tick) begin
      now_ms++;
      if (holding) begin
        if (hold_count <= 1) begin
          holding    = 1'b0;
          hold_count = '0;
          outs.push_back(parked_report());
        end else begin
          hold_count--;
        end
      end
    end else begin
      case (kind)
        ClsDown: begin
          if (within_dist(t.x, lift_x, spot_dx) && within_dist(t.y, lift_y, spot_dy) &&
              (now_ms - lift_ms) <= ClockW'(retap_window)) begin
            // suspect re-tap: park it, restarting any hold already running
            parked_x     = t.x;
            parked_y     = t.y;
            parked_other = t.other_bits;
            holding      = 1'b1;
            hold_count   = park_ticks;
          end else begin
            anchor_x = t.x;
            anchor_y = t.y;
            holding  = 1'b0;
            outs.push_back(echo_report(t));
          end
        end
        ClsUp: begin
          lift_x  = t.x;
          lift_y  = t.y;
          lift_ms = now_ms;
          if (holding) holding = 1'b0;
          else outs.push_back(echo_report(t));
        end
        ClsMove: begin
          // a move inside the spot around the anchor keeps the pen-down parked
          if (!(holding && within_dist(t.x, anchor_x, spot_dx) &&
                within_dist(t.y, anchor_y, spot_dy))) begin
            if (holding) begin
              holding = 1'b0;
              outs.push_back(parked_report());
            end
            if (!(within_dist(t.x, anchor_x, jog_min) && within_dist(t.y, anchor_y, jog_min)))
            begin
              anchor_x = t.x;
              anchor_y = t.y;
              outs.push_back(echo_report(t));
            end
          end
        end
        ClsHover: ;
        default: outs.push_back(echo_report(t));
      endcase
    end
    if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1'b1;
    foreach (outs[i]) reports_due.push_back(outs[i]);
  endfunction

  function automatic touch_t random_touch();
    logic [PayW-1:0] bits;
    bits = PayW'({$urandom, $urandom});
    return touch_t'(bits);
  endfunction

  function automatic logic signed [CoordBits-1:0] offset(input int span);
    return CoordBits'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // leave in_valid high on return so back-to-back items need no toggle
  task automatic send_item(input logic cmd, input touch_t t);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_data  <= DataW'(t);
    predict_reports(cmd, t);
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic stop_send();
    in_valid <= 1'b0;
  endtask

  task automatic send_touch(input logic [FlagW-1:0] kind, input logic [OtherW-1:0] other,
                            input logic signed [CoordBits-1:0] x,
                            input logic signed [CoordBits-1:0] y);
    touch_t t;
    {t.valid_bit, t.down_bit, t.prev_down_bit, t.ignore_bit} = kind;
    t.other_bits = other;
    t.x          = x;
    t.y          = y;
    send_item(1'b0, t);
  endtask

  task automatic send_ticks(input int count);
    int i;
    for (i = 0; i < count; i++) send_item(1'b1, random_touch());
  endtask

  task automatic wait_drain();
    stop_send();
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_config(input logic [CfgW-1:0] ax, input logic [CfgW-1:0] ay,
                              input logic [CfgW-1:0] window, input logic [CfgW-1:0] ticks,
                              input logic [CfgW-1:0] jog);
    cfg_idx_e        regs[NumRegs];
    logic [CfgW-1:0] vals[NumRegs];
    int              i;
    regs = '{CfgAreaX, CfgAreaY, CfgRepeat, CfgHoldDelay, CfgMoveStep};
    vals = '{ax, ay, window, ticks, jog};
    wait_drain();
    for (i = 0; i < NumRegs; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      case (regs[i])
        CfgAreaX:     spot_dx      = vals[i];
        CfgAreaY:     spot_dy      = vals[i];
        CfgRepeat:    retap_window = vals[i];
        CfgHoldDelay: park_ticks   = vals[i];
        CfgMoveStep:  jog_min      = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // down near the last lift point or anywhere, up to six moves, then lift
  task automatic send_stroke(input int jitter, input int gap);
    logic signed [CoordBits-1:0] px, py;
    int                          n_moves, i, span;
    if ($urandom_range(0, 3) == 0) begin
      px = CoordBits'($urandom);
      py = CoordBits'($urandom);
    end else begin
      px = lift_x + offset(jitter);
      py = lift_y + offset(jitter);
    end
    send_touch(ClsDown, OtherW'($urandom), px, py);
    n_moves = $urandom_range(0, 6);
    for (i = 0; i < n_moves; i++) begin
      send_ticks($urandom_range(0, gap));
      span = ($urandom_range(0, 4) == 0) ? 200 : 12;
      px   = px + offset(span);
      py   = py + offset(span);
      send_touch(ClsMove, OtherW'($urandom), px, py);
    end
    send_ticks($urandom_range(0, gap));
    send_touch(ClsUp, OtherW'($urandom), px, py);
  endtask

  task automatic run_traffic(input int n_items, input int gap, input int long_rest);
    int stop_at, pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        send_item(1'($urandom), random_touch());
      end else if (pick == 3) begin
        wait_drain();
      end else begin
        send_stroke((pick < 7) ? 0 : 24, gap);
        send_ticks($urandom_range(0, 3));
        if (long_rest > 0 && $urandom_range(0, 7) == 0)
          send_ticks(long_rest + $urandom_range(0, 10));
      end
    end
  endtask

  task automatic test_directed();
    // reset values: the first down sits on the zeroed lift record
    send_touch(ClsDown, 8'h00, 0, 0);
    send_touch(ClsUp, 8'hFF, 0, 0);
    send_touch(ClsDown, 8'h5A, 500, 500);
    write_config(16, 8, 1, 2, 5);
    send_touch(ClsDown, 8'hA5, 0, 0);
    send_ticks(2);
    send_touch(ClsUp, 8'h0F, 3, 3);
    send_touch(ClsDown, 8'hF0, 5, 5);
    send_touch(ClsUp, 8'h33, 5, 5);
    send_touch(ClsDown, 8'h3C, 5, 14);
    send_touch(ClsDown, 8'hC3, 21, 5);
    send_touch(ClsMove, 8'h11, 10, 10);
    send_touch(ClsMove, 8'h22, 100, -100);
    send_touch(ClsMove, 8'h44, 102, -105);
    send_touch(ClsMove, 8'h88, MinCoord, MaxCoord);
    send_touch(ClsUp, 8'h77, MaxCoord, MinCoord);
    send_ticks(2);
    send_touch(ClsDown, 8'hEE, MaxCoord, MinCoord);
    send_touch(ClsHover, 8'h99, 7, 7);
    send_touch(OddFlags, 8'hFF, MaxCoord, MinCoord);
    send_touch(DownIgnored, 8'h00, MinCoord, MaxCoord);
    send_touch(ClsUp, 8'h12, 1, 1);
    send_touch(ClsDown, 8'h34, 1, 1);
    send_touch(ClsDown, 8'h56, 2, 2);
    send_ticks(2);
  endtask

  task automatic test_reset_values();
    write_config(16, 16, 300, 100, 5);
    run_traffic(350, 3, 95);
  endtask

  task automatic test_tight_timing();
    write_config(16, 12, 20, 3, 5);
    run_traffic(550, 2, 25);
  endtask

  task automatic test_zero_limits();
    write_config(0, 0, 0, 1, 0);
    run_traffic(250, 2, 0);
  endtask

  task automatic test_full_limits();
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(200, 3, 0);
  endtask

  // hold the output off while pass-through items keep coming, then drain
  task automatic test_backpressure();
    touch_t t;
    int     i;
    write_config(16, 16, 300, 100, 5);
    rx_holdoff = HoldoffCycles;
    for (i = 0; i < 60; i++) begin
      t           = random_touch();
      t.valid_bit = 1'b0;
      send_item(1'b0, t);
    end
    wait_drain();
  endtask

  task automatic test_random_settings();
    int round;
    for (round = 0; round < 3; round++) begin
      if (round == 0) begin
        write_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(1, 65535),
                     $urandom_range(0, 65535));
      end else begin
        // no idling in the closing stretch
        if (round == 2) begin
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
        end
        write_config($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 60),
                     $urandom_range(1, 6), $urandom_range(0, 12));
      end
      run_traffic(150, 3, 0);
    end
  endtask

  initial begin : sink
    forever begin
      @(posedge clk);
      if (rx_holdoff > 0) begin
        out_ready <= 1'b0;
        repeat (rx_holdoff) @(posedge clk);
        rx_holdoff = 0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_output
    touch_t word;
    res_t   got, want;
    if (out_valid && out_ready) begin
      word              = out_data[PayW-1:0];
      got.valid_bit     = word.valid_bit;
      got.down_bit      = word.down_bit;
      got.prev_down_bit = word.prev_down_bit;
      got.ignore_bit    = word.ignore_bit;
      got.other_bits    = word.other_bits;
      got.x             = word.x;
      got.y             = word.y;
      got.from_hold     = out_hold;
      got.last_of_run   = out_last;
      if (reports_due.size() == 0) begin
        if (mismatch_count < 10) $display("%0t: output item with none due: %p", $time, got);
        mismatch_count++;
      end else begin
        want = reports_due.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) $display("%0t: expected %p, got %p", $time, want, got);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("touch_tap_repeat_filter test failed");
    $finish;
  end

  initial begin : run
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_reset_values();
    test_tight_timing();
    test_zero_limits();
    test_full_limits();
    test_backpressure();
    test_random_settings();
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && reports_due.size() == 0) begin
      $display("touch_tap_repeat_filter test passed");
    end else begin
      $display("touch_tap_repeat_filter test failed");
    end
    $finish;
  end

endmodule
